// ===== hdl/wto_pkg.sv =====
// Shared constants, types and sine table generation for the wavetable oscillator.
`timescale 1ns / 1ps

package wto_pkg;

   // Sizes
   localparam int TABLE_DEPTH    = 512;
   localparam int SAMPLE_BITS    = 16;
   localparam int PHASE_BITS     = 32;
   localparam int INDEX_BITS     = $clog2(TABLE_DEPTH);

   // Stored quarter wave: entries 0 .. TABLE_DEPTH/4 inclusive
   localparam int SINE_DEPTH     = TABLE_DEPTH / 4 + 1;
   localparam int SINE_ADDR_BITS = $clog2(SINE_DEPTH);
   localparam int FILL_CNT_BITS  = $clog2(SINE_DEPTH + 1);

   // Control register port
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int INCR_BITS      = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_PHASE_INCREMENT = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] REG_WAVE_SHAPE      = CSR_INDEX_BITS'(1);

   typedef enum logic [1:0] {
      SHAPE_SINE     = 2'd0,
      SHAPE_SQUARE   = 2'd1,
      SHAPE_SAW      = 2'd2,
      SHAPE_TRIANGLE = 2'd3
   } shape_type;

   // pi in Q30
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   typedef logic [SAMPLE_BITS-1:0] sine_rom_type [SINE_DEPTH];

   // Sine magnitude of table point r (first quarter), Taylor series through x^15 in Q30
   function automatic logic [SAMPLE_BITS-1:0] sine_magnitude(input int unsigned r);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned rounded;
      x    = (64'd2 * PI_Q30 * 64'(r) + 64'(TABLE_DEPTH / 2)) >> INDEX_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      // each term divides by (2k)(2k+1): 6, 20, 42, 72, 110, 156, 210
      term = ((term * x2) >> 30) / 64'd6;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - longint'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + longint'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - longint'(term);
      if (sum < 0) sum = 0;
      rounded = (64'(sum) + (64'd1 << (30 - SAMPLE_BITS))) >> (31 - SAMPLE_BITS);
      return SAMPLE_BITS'(rounded);
   endfunction

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int unsigned r = 0; r < SINE_DEPTH; r++) begin
         rom[r] = sine_magnitude(r);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Control carried with an item between the table read and the output register
   typedef struct packed {
      logic                  valid;
      shape_type             shape;
      logic [INDEX_BITS-1:0] index;
   } stage_ctrl_type;

endpackage

// ===== hdl/wto_channels.sv =====
// Handshake channel interfaces for the wavetable oscillator.
`timescale 1ns / 1ps

interface wto_req_if;
   logic valid;
   logic ready;
   logic restart;
   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface wto_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [wto_pkg::SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

interface wto_csr_if;
   logic                               valid;
   logic                               ready;
   logic [wto_pkg::CSR_INDEX_BITS-1:0] index;
   logic [wto_pkg::CSR_DATA_BITS-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/wavetable_oscillator.sv =====
// Wavetable oscillator top level: phase accumulator, sine table RAM and wave shaping.
`timescale 1ns / 1ps

// Direct digital synthesis oscillator.
// req_bus: one transfer per sample; restart = 1 zeroes the phase before that sample.
// rsp_bus: one signed Q1.15 sample per request, in request order.
// csr_bus: register writes (0 phase_increment, 1 wave_shape), always ready; write
//   only while no sample is in flight. Unknown indexes are ignored.
// Path: a sample passes the sine RAM read, registered with the read stage, and
//   then the output register before it is offered on rsp_bus.
// Throughput: one sample per cycle while rsp_bus.ready stays high; the phase add
//   feeds back through the phase register and the sine RAM takes one read per cycle.
// Reset: registers and phase clear to zero, then the quarter-wave sine RAM is
//   loaded with TABLE_DEPTH/4+1 = 129 entries, one entry per cycle; req_bus.ready
//   stays low during that load. Register writes are taken throughout.
// Stall: while rsp_bus.ready is low the output register holds its sample, one
//   more request is still taken into the read stage, and then req_bus.ready drops.
module wavetable_oscillator (
   input  logic    clock,
   input  logic    reset,
   wto_req_if.sink   req_bus,
   wto_rsp_if.source rsp_bus,
   wto_csr_if.sink   csr_bus
);

   localparam int IB   = wto_pkg::INDEX_BITS;
   localparam int SB   = wto_pkg::SAMPLE_BITS;
   localparam int PB   = wto_pkg::PHASE_BITS;
   localparam int SAB  = wto_pkg::SINE_ADDR_BITS;
   localparam int WIDE = SB + 3;
   localparam int PROD = IB + SB + 1;

   // Control registers
   logic [wto_pkg::INCR_BITS-1:0] incr_ff, incr_in;
   wto_pkg::shape_type            shape_ff, shape_in;

   always_comb begin
      incr_in  = incr_ff;
      shape_in = shape_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            wto_pkg::REG_PHASE_INCREMENT: incr_in = wto_pkg::INCR_BITS'(csr_bus.data);
            wto_pkg::REG_WAVE_SHAPE:      shape_in = wto_pkg::shape_type'(csr_bus.data[1:0]);
            default: ;
         endcase
      end
   end

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         incr_ff  <= '0;
         shape_ff <= wto_pkg::SHAPE_SINE;
      end else begin
         incr_ff  <= incr_in;
         shape_ff <= shape_in;
      end
   end

   // Sine RAM load after reset
   logic [wto_pkg::FILL_CNT_BITS-1:0] fill_cnt_ff, fill_cnt_in;
   logic                              fill_done;

   assign fill_done   = (fill_cnt_ff == wto_pkg::FILL_CNT_BITS'(wto_pkg::SINE_DEPTH));
   assign fill_cnt_in = fill_done ? fill_cnt_ff : fill_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) fill_cnt_ff <= '0;
      else       fill_cnt_ff <= fill_cnt_in;
   end

   // Handshake and pipeline control
   wto_pkg::stage_ctrl_type s1_ff, s1_in;
   logic                    out_valid_ff, out_valid_in;
   logic                    out_free, s1_adv, accept;

   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign s1_adv        = s1_ff.valid && out_free;
   assign req_bus.ready = fill_done && (!s1_ff.valid || out_free);
   assign accept        = req_bus.valid && req_bus.ready;

   // Phase accumulator and table index
   logic [PB-1:0] phase_ff, phase_in, phase_used;
   logic [IB-1:0] index;

   assign phase_used = req_bus.restart ? '0 : phase_ff;
   assign index      = phase_used[PB-1 -: IB];
   assign phase_in   = accept ? phase_used + PB'(incr_ff) : phase_ff;

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= '0;
      else       phase_ff <= phase_in;
   end

   // Fold the index into the first quarter for the sine read
   logic [IB-2:0]  fold_r;
   logic [SAB-1:0] sine_addr;

   always_comb begin
      fold_r = index[IB-2:0];
      if (IB'(fold_r) > IB'(wto_pkg::TABLE_DEPTH / 4)) begin
         sine_addr = SAB'(IB'(wto_pkg::TABLE_DEPTH / 2) - IB'(fold_r));
      end else begin
         sine_addr = SAB'(fold_r);
      end
   end

   logic [SB-1:0] sine_mag;

   wto_ram #(
      .WIDTH (SB),
      .DEPTH (wto_pkg::SINE_DEPTH)
   ) u_sine_ram (
      .clock   (clock),
      .wr_en   (!fill_done),
      .wr_addr (fill_cnt_ff[SAB-1:0]),
      .wr_data (wto_pkg::SINE_ROM[fill_cnt_ff[SAB-1:0]]),
      .rd_en   (accept),
      .rd_addr (sine_addr),
      .rd_data (sine_mag)
   );

   // Read stage control
   always_comb begin
      s1_in = s1_ff;
      if (accept) begin
         s1_in.valid = 1'b1;
         s1_in.shape = shape_ff;
         s1_in.index = index;
      end else if (s1_adv) begin
         s1_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else begin
         s1_ff.valid <= s1_in.valid;
      end
      s1_ff.shape <= s1_in.shape;
      s1_ff.index <= s1_in.index;
   end

   // Wave shaping
   logic                   second_half;
   logic [IB-2:0]          tri_i;
   logic [PROD-1:0]        saw_q, tri_q;
   logic signed [WIDE-1:0] full, wave_v;
   logic [SB-1:0]          sample_in;

   assign second_half = s1_ff.index[IB-1];
   assign tri_i       = s1_ff.index[IB-2:0];
   assign full        = WIDE'(signed'({1'b0, 1'b1, {(SB-1){1'b0}}}));
   assign saw_q       = (PROD'(s1_ff.index) << SB) >> IB;
   assign tri_q       = (PROD'(tri_i) << (SB + 1)) >> IB;

   always_comb begin
      case (s1_ff.shape)
         wto_pkg::SHAPE_SINE: begin
            wave_v = second_half ? -signed'(WIDE'(sine_mag)) : signed'(WIDE'(sine_mag));
         end
         wto_pkg::SHAPE_SQUARE: begin
            wave_v = second_half ? -full : full;
         end
         wto_pkg::SHAPE_SAW: begin
            wave_v = full - signed'(WIDE'(saw_q));
         end
         default: begin
            wave_v = second_half ? full - signed'(WIDE'(tri_q))
                                 : signed'(WIDE'(tri_q)) - full;
         end
      endcase
      // +1.0 saturates to the largest positive code
      if (wave_v > full - WIDE'(1)) begin
         sample_in = SB'(full - WIDE'(1));
      end else if (wave_v < -full) begin
         sample_in = SB'(-full);
      end else begin
         sample_in = SB'(wave_v);
      end
   end

   // Output register
   logic [SB-1:0] sample_ff;

   assign out_valid_in = s1_adv ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
      if (s1_adv) begin
         sample_ff <= sample_in;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.sample_out = signed'(sample_ff);

endmodule

// ===== hdl/wto_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module wto_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
